### hw/rtl/deq_pkg.sv
// Shared types, codes and constants of the double-ended queue.
package deq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = $clog2(DEPTH_DEF + 1);

  // Request codes.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Bit pattern of -1.0 in single precision.
  localparam logic [WORD_W-1:0] NEG_ONE_BITS = 32'hBF80_0000;

  // Cell operations.
  localparam logic [1:0] CELL_HOLD       = 2'd0;
  localparam logic [1:0] CELL_SHIFT_DOWN = 2'd1;
  localparam logic [1:0] CELL_SHIFT_UP   = 2'd2;
  localparam logic [1:0] CELL_WRITE_AT   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
  } cell_ctl_t;

endpackage

### hw/rtl/deq_if.sv
// Request and response channel interfaces of the double-ended queue.
interface deq_req_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::MODE_W-1:0]  mode;
  logic [deq_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int CNT_W = deq_pkg::OCC_W
);
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::WORD_W-1:0]    pop_value;
  logic [deq_pkg::STATUS_W-1:0]  status;
  logic [CNT_W-1:0]              occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

### hw/rtl/double_ended_queue_core.sv
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle; ready drops only while a result waits unread.
// Both queue ends sit at cell zero of their own chain, so no request waits on a search.
// Reset clears the entry count and the result valid; the cell words stay unknown
// until written, and a word is only ever popped after a push has written it.
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  deq_req_if.sink       req,
  deq_rsp_if.source     rsp
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // Two mirrored chains hold the same entries. In the front chain cell i holds
  // the i-th entry counted from the front; in the back chain cell i holds the
  // i-th entry counted from the back. A push or pop at one end shifts the chain
  // of that end and, for a push, writes the far end of the other chain at the
  // cell given by the count. A pop leaves the other chain alone: its last valid
  // cell simply falls out of range when the count drops.
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  cell_ctl_t           ctl_front;
  cell_ctl_t           ctl_back;
  logic [WORD_W-1:0]   front_word;
  logic [WORD_W-1:0]   back_word;

  logic                accept;
  logic                full;
  logic                empty;

  logic                rsp_valid;
  logic [WORD_W-1:0]   pop_value;
  logic [WORD_W-1:0]   pop_value_next;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W-1:0]    occupancy;

  // The output register frees up in the same cycle it is read.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);

  always_comb begin
    ctl_front.op   = CELL_HOLD;
    ctl_back.op    = CELL_HOLD;
    count_next     = count;
    pop_value_next = '0;
    status_next    = ST_OK;
    case (req.mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl_front.op = CELL_SHIFT_DOWN;
          ctl_back.op  = CELL_WRITE_AT;
          count_next   = count + 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl_back.op  = CELL_SHIFT_DOWN;
          ctl_front.op = CELL_WRITE_AT;
          count_next   = count + 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_next    = ST_EMPTY;
          pop_value_next = NEG_ONE_BITS;
        end else begin
          ctl_front.op   = CELL_SHIFT_UP;
          pop_value_next = front_word;
          count_next     = count - 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_next    = ST_EMPTY;
          pop_value_next = NEG_ONE_BITS;
        end else begin
          ctl_back.op    = CELL_SHIFT_UP;
          pop_value_next = back_word;
          count_next     = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    // Nothing moves unless a request beat is actually taken.
    if (!accept) begin
      ctl_front.op = CELL_HOLD;
      ctl_back.op  = CELL_HOLD;
      count_next   = count;
    end
  end

  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front (
    .clk        (clk),
    .ctl        (ctl_front),
    .count      (count),
    .push_value (req.push_value),
    .end_word   (front_word)
  );

  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_back (
    .clk        (clk),
    .ctl        (ctl_back),
    .count      (count),
    .push_value (req.push_value),
    .end_word   (back_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload is captured with its request and held while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_value <= pop_value_next;
      status    <= status_next;
      occupancy <= count_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.pop_value = pop_value;
  assign rsp.status    = status;
  assign rsp.occupancy = occupancy;

endmodule

### hw/rtl/deq_cell.sv
// One storage cell of a queue chain: holds a word and trades it with its neighbors.
module deq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = deq_pkg::OCC_W
) (
  input  logic                       clk,
  input  deq_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]           count,
  input  logic [deq_pkg::WORD_W-1:0] from_lower,
  input  logic [deq_pkg::WORD_W-1:0] from_upper,
  input  logic [deq_pkg::WORD_W-1:0] push_value,
  output logic [deq_pkg::WORD_W-1:0] word
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_SHIFT_DOWN: word <= from_lower;
      CELL_SHIFT_UP:   word <= from_upper;
      CELL_WRITE_AT: begin
        if (count == IDX) begin
          word <= push_value;
        end
      end
      default: word <= word;
    endcase
  end

endmodule

### hw/rtl/deq_chain.sv
// A row of cells that keeps the queue ordered from one end, end word at cell zero.
module deq_chain #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  deq_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]           count,
  input  logic [deq_pkg::WORD_W-1:0] push_value,
  output logic [deq_pkg::WORD_W-1:0] end_word
);
  import deq_pkg::*;

  logic [WORD_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = push_value;
    end else begin : g_inner_lo
      assign lower = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner_hi
      assign upper = words[i+1];
    end

    deq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .from_lower (lower),
      .from_upper (upper),
      .push_value (push_value),
      .word       (words[i])
    );
  end

  assign end_word = words[0];

endmodule
